/* sv/scb_pkg.sv */
// Shared types, codes, constants and helper functions of the shade command batcher.
package scb_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int FULL_SCALE   = 1000;
   localparam int MAX_HOLD_MS  = 10000;

   localparam int CH_W    = 3;
   localparam int CMD_W   = 3;
   localparam int POS_W   = 10;
   localparam int TIME_W  = 32;
   localparam int CNT_W   = 4;
   localparam int HOLD_W  = 14;
   localparam int GAP_W   = 16;
   localparam int PROD_W  = TIME_W + POS_W;
   localparam int DIV_STEP_W = $clog2(PROD_W + 1);
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [1:0]        conf_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [POS_W-1:0]  pos_type;

   localparam cmd_type CMD_NONE    = 3'd0;
   localparam cmd_type CMD_UP      = 3'd1;
   localparam cmd_type CMD_DOWN    = 3'd2;
   localparam cmd_type CMD_STOP    = 3'd3;
   localparam cmd_type CMD_INTERIM = 3'd4;

   localparam conf_type CONF_UNKNOWN   = 2'd0;
   localparam conf_type CONF_ESTIMATED = 2'd1;
   localparam conf_type CONF_EXACT     = 2'd2;

   localparam logic [1:0] MODE_CMD    = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_LOAD   = 2'd2;
   localparam logic [1:0] MODE_REPORT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERIM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP     = 2'd3;

   localparam logic [HOLD_W-1:0] PULSE_DFLT   = 14'd500;
   localparam logic [HOLD_W-1:0] INTERIM_DFLT = 14'd3000;
   localparam logic [GAP_W-1:0]  GAP_DFLT     = 16'd250;
   localparam logic [CNT_W-1:0]  COUNT_DFLT   = 4'd8;

   // Substitute the default for zero, then clip at the maximum hold
   function automatic logic [HOLD_W-1:0] eff_hold(input logic [HOLD_W-1:0] v,
                                                  input logic [HOLD_W-1:0] dflt);
      logic [HOLD_W-1:0] t;
      t = (v == '0) ? dflt : v;
      if (t > HOLD_W'(MAX_HOLD_MS)) t = HOLD_W'(MAX_HOLD_MS);
      return t;
   endfunction

   // Wrap-safe deadline test
   function automatic logic reached(input time_type now, input time_type deadline);
      time_type d;
      d = now - deadline;
      return ~d[TIME_W-1];
   endfunction

endpackage

/* sv/scb_if.sv */
// Channel interfaces: request, response and register write.
interface scb_req_if import scb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       mode;
   logic [CH_W-1:0]  channel;
   cmd_type          command;
   time_type         now_ms;
   time_type         travel_up;
   time_type         travel_down;
   modport source (output valid, mode, channel, command, now_ms, travel_up, travel_down,
                   input ready);
   modport sink   (input valid, mode, channel, command, now_ms, travel_up, travel_down,
                   output ready);
endinterface

interface scb_rsp_if import scb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       accepted;
   cmd_type    batch_cmd;
   logic [7:0] assert_mask;
   logic       busy_res;
   pos_type    position;
   conf_type   confidence;
   logic       moving;
   cmd_type    released_cmd;
   modport source (output valid, accepted, batch_cmd, assert_mask, busy_res, position,
                   confidence, moving, released_cmd, input ready);
   modport sink   (input valid, accepted, batch_cmd, assert_mask, busy_res, position,
                   confidence, moving, released_cmd, output ready);
endinterface

interface scb_csr_if import scb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/scb_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module scb_div import scb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] numer,
   input  time_type          denom,
   output logic              done,
   output logic [PROD_W-1:0] quot
);
   logic [PROD_W-1:0]     q_ff, q_in;
   logic [TIME_W:0]       rem_ff, rem_in;
   time_type              den_ff, den_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [TIME_W:0]       rem_sh;

   // One shift-subtract step per cycle
   always_comb begin
      q_in = q_ff; rem_in = rem_ff; den_in = den_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      rem_sh = {rem_ff[TIME_W-1:0], q_ff[PROD_W-1]};
      if (start) begin
         q_in = numer; rem_in = '0; den_in = denom;
         step_in = DIV_STEP_W'(PROD_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[PROD_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without a running division");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff != DIV_STEP_W'(1) |=> busy_ff || start)
      else $error("divider stopped early");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < {1'b0, den_ff}) else $error("remainder not below divisor");
endmodule

/* sv/shade_command_batcher.sv */
// Top level: shade command batcher sequencer with shared serial divider.
// Usage:
//   req_ch carries one item: mode 0 records a command request for a channel,
//   mode 1 is a millisecond tick, mode 2 loads a channel's travel times,
//   mode 3 only reports. Each item yields exactly one item on rsp_ch with the
//   contact command and mask, the busy flag and the named channel's status.
//   csr_ch writes the four registers (channel count, pulse hold, intermediate
//   hold, guard gap); it is always ready. The user must write it only while
//   idle; the block does not enforce this.
// Sequencing: command, load and report items pass the accept state, then the
//   report state. A tick walks the channels one per cycle; a moving, modelled
//   channel instead needs the visit that forms the product, a start state, 42
//   divider steps and the divide state taking the quotient. The tick then
//   either applies an ended pulse (one more walk) or scans for the oldest
//   request and, if one is found, gathers the batch (two more walks).
//   req_ch.ready is high only while the sequencer is idle.
// Reset: synchronous; clears all channel state, requests and registers to
//   their defaults (8 channels, 500 ms, 3000 ms, 250 ms).
// Stall: a finished result sits in the output register; the next item is
//   taken meanwhile, and its own result waits until the previous one leaves.
module shade_command_batcher import scb_pkg::*; (
   input logic     clock,
   input logic     reset,
   scb_req_if.sink   req_ch,
   scb_rsp_if.source rsp_ch,
   scb_csr_if.sink   csr_ch
);
   typedef enum logic [3:0] {
      S_IDLE, S_ADV, S_START, S_DIV, S_PULSE, S_EFFECT,
      S_GAP, S_SCAN, S_GATHER, S_REPORT
   } state_type;

   state_type state_ff;

   // Registers
   logic [CNT_W-1:0]  count_cfg_ff;
   logic [HOLD_W-1:0] pulse_cfg_ff, interim_cfg_ff;
   logic [GAP_W-1:0]  gap_cfg_ff;

   // Per-channel state
   cmd_type  pending_cmd_ff   [MAX_CHANNELS];
   time_type pending_stamp_ff [MAX_CHANNELS];
   pos_type  channel_pos_ff   [MAX_CHANNELS];
   conf_type channel_conf_ff  [MAX_CHANNELS];
   logic     channel_moving_ff[MAX_CHANNELS];
   logic     channel_up_ff    [MAX_CHANNELS];
   time_type move_start_time_ff[MAX_CHANNELS];
   pos_type  move_start_pos_ff[MAX_CHANNELS];
   cmd_type  channel_last_ff  [MAX_CHANNELS];
   time_type travel_up_ff     [MAX_CHANNELS];
   time_type travel_down_ff   [MAX_CHANNELS];

   time_type   request_counter_ff;
   cmd_type    active_cmd_ff;
   logic [7:0] active_mask_ff;
   time_type   pulse_end_ff;
   logic       gap_active_ff;
   time_type   gap_end_ff;

   // Item being worked on
   logic [CH_W-1:0]   ch_ff;
   time_type          now_ff;
   logic              acc_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] prod_ff;
   time_type          span_ff;
   cmd_type           want_ff;
   time_type          oldest_ff;
   logic [7:0]        mask_ff;

   // Response register
   logic       rsp_valid_ff, rsp_acc_ff, rsp_busy_ff, rsp_moving_ff;
   cmd_type    rsp_cmd_ff, rsp_last_ff;
   logic [7:0] rsp_mask_ff;
   pos_type    rsp_pos_ff;
   conf_type   rsp_conf_ff;

   logic [CNT_W-1:0]  n_eff;
   logic [CH_W-1:0]   idx;
   logic              idx_end;
   logic [7:0]        used_mask;
   logic              any_pending;
   time_type          span_sel;
   time_type          elapsed;
   logic              div_start, div_done;
   logic [PROD_W-1:0] div_quot;
   logic [PROD_W:0]   up_sum;
   logic              ch_ok;
   logic              cmd_ok;
   logic              rsp_load;

   // Effective channel count and derived masks
   always_comb begin
      if (count_cfg_ff == '0) n_eff = CNT_W'(1);
      else if (count_cfg_ff > CNT_W'(MAX_CHANNELS)) n_eff = CNT_W'(MAX_CHANNELS);
      else n_eff = count_cfg_ff;
      any_pending = 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         used_mask[i] = (CNT_W'(i) < n_eff);
         if (used_mask[i] && pending_cmd_ff[i] != CMD_NONE) any_pending = 1'b1;
      end
   end

   assign idx       = cnt_ff[CH_W-1:0];
   assign idx_end   = (cnt_ff >= n_eff);
   assign span_sel  = channel_up_ff[idx] ? travel_up_ff[idx] : travel_down_ff[idx];
   assign elapsed   = now_ff - move_start_time_ff[idx];
   assign div_start = (state_ff == S_START);
   assign up_sum    = {1'b0, div_quot} + (PROD_W+1)'(move_start_pos_ff[idx]);
   assign ch_ok     = ({1'b0, ch_ff} < n_eff);
   assign cmd_ok    = (req_ch.mode == MODE_CMD) && ({1'b0, req_ch.channel} < n_eff)
                      && req_ch.command != CMD_NONE && req_ch.command <= CMD_INTERIM;
   assign rsp_load  = (state_ff == S_REPORT) && (!rsp_valid_ff || rsp_ch.ready);

   scb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_ff),
      .denom (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = rsp_acc_ff;
   assign rsp_ch.batch_cmd    = rsp_cmd_ff;
   assign rsp_ch.assert_mask  = rsp_mask_ff;
   assign rsp_ch.busy_res     = rsp_busy_ff;
   assign rsp_ch.position     = rsp_pos_ff;
   assign rsp_ch.confidence   = rsp_conf_ff;
   assign rsp_ch.moving       = rsp_moving_ff;
   assign rsp_ch.released_cmd = rsp_last_ff;

   // Sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_cfg_ff   <= COUNT_DFLT;
         pulse_cfg_ff   <= PULSE_DFLT;
         interim_cfg_ff <= INTERIM_DFLT;
         gap_cfg_ff     <= GAP_DFLT;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            pending_cmd_ff[i]     <= CMD_NONE;
            pending_stamp_ff[i]   <= '0;
            channel_pos_ff[i]     <= '0;
            channel_conf_ff[i]    <= CONF_UNKNOWN;
            channel_moving_ff[i]  <= 1'b0;
            channel_up_ff[i]      <= 1'b0;
            move_start_time_ff[i] <= '0;
            move_start_pos_ff[i]  <= '0;
            channel_last_ff[i]    <= CMD_NONE;
            travel_up_ff[i]       <= '0;
            travel_down_ff[i]     <= '0;
         end
         request_counter_ff <= '0;
         active_cmd_ff  <= CMD_NONE;
         active_mask_ff <= '0;
         pulse_end_ff   <= '0;
         gap_active_ff  <= 1'b0;
         gap_end_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         // Register writes
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_COUNT:   count_cfg_ff   <= csr_ch.data[CNT_W-1:0];
               CSR_PULSE:   pulse_cfg_ff   <= csr_ch.data[HOLD_W-1:0];
               CSR_INTERIM: interim_cfg_ff <= csr_ch.data[HOLD_W-1:0];
               CSR_GAP:     gap_cfg_ff     <= csr_ch.data[GAP_W-1:0];
               default: ;
            endcase
         end
         // Drop a taken response unless a new one is loaded
         if (rsp_valid_ff && rsp_ch.ready && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  ch_ff   <= req_ch.channel;
                  now_ff  <= req_ch.now_ms;
                  if (req_ch.mode == MODE_TICK) begin
                     acc_ff   <= 1'b0;
                     cnt_ff   <= '0;
                     state_ff <= S_ADV;
                  end else begin
                     acc_ff   <= cmd_ok;
                     cnt_ff   <= {1'b0, req_ch.channel};
                     state_ff <= S_REPORT;
                     if (cmd_ok) begin
                        request_counter_ff <= request_counter_ff + 1'b1;
                        pending_cmd_ff[req_ch.channel]   <= req_ch.command;
                        pending_stamp_ff[req_ch.channel] <= request_counter_ff + 1'b1;
                     end
                     if (req_ch.mode == MODE_LOAD) begin
                        travel_up_ff[req_ch.channel]   <= req_ch.travel_up;
                        travel_down_ff[req_ch.channel] <= req_ch.travel_down;
                     end
                  end
               end
            end
            S_ADV: begin
               // Dead-reckon one channel per visit
               if (idx_end) begin
                  state_ff <= S_PULSE;
               end else if (!channel_moving_ff[idx]) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else if (span_sel == '0) begin
                  channel_conf_ff[idx] <= CONF_UNKNOWN;
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  prod_ff  <= PROD_W'(elapsed) * PROD_W'(FULL_SCALE);
                  span_ff  <= span_sel;
                  state_ff <= S_START;
               end
            end
            S_START: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  if (channel_up_ff[idx]) begin
                     if (up_sum >= (PROD_W+1)'(FULL_SCALE)) begin
                        channel_pos_ff[idx]    <= POS_W'(FULL_SCALE);
                        channel_moving_ff[idx] <= 1'b0;
                        channel_conf_ff[idx]   <= CONF_EXACT;
                     end else begin
                        channel_pos_ff[idx]  <= up_sum[POS_W-1:0];
                        channel_conf_ff[idx] <= CONF_ESTIMATED;
                     end
                  end else begin
                     if (div_quot >= PROD_W'(move_start_pos_ff[idx])) begin
                        channel_pos_ff[idx]    <= '0;
                        channel_moving_ff[idx] <= 1'b0;
                        channel_conf_ff[idx]   <= CONF_EXACT;
                     end else begin
                        channel_pos_ff[idx]  <= move_start_pos_ff[idx] - div_quot[POS_W-1:0];
                        channel_conf_ff[idx] <= CONF_ESTIMATED;
                     end
                  end
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_ADV;
               end
            end
            S_PULSE: begin
               cnt_ff <= '0;
               if (active_cmd_ff != CMD_NONE && reached(now_ff, pulse_end_ff))
                  state_ff <= S_EFFECT;
               else
                  state_ff <= S_GAP;
            end
            S_EFFECT: begin
               // Apply the ended pulse to each asserted channel
               if (idx_end) begin
                  active_cmd_ff  <= CMD_NONE;
                  active_mask_ff <= '0;
                  gap_active_ff  <= 1'b1;
                  gap_end_ff <= now_ff + TIME_W'((gap_cfg_ff == '0) ? GAP_DFLT : gap_cfg_ff);
                  state_ff <= S_GAP;
               end else begin
                  if (active_mask_ff[idx]) begin
                     channel_last_ff[idx] <= active_cmd_ff;
                     if (active_cmd_ff == CMD_UP || active_cmd_ff == CMD_DOWN) begin
                        channel_moving_ff[idx]  <= 1'b1;
                        channel_up_ff[idx]      <= (active_cmd_ff == CMD_UP);
                        move_start_time_ff[idx] <= now_ff;
                        move_start_pos_ff[idx]  <= channel_pos_ff[idx];
                        if (channel_conf_ff[idx] == CONF_EXACT)
                           channel_conf_ff[idx] <= CONF_ESTIMATED;
                     end else if (active_cmd_ff == CMD_STOP) begin
                        channel_moving_ff[idx] <= 1'b0;
                     end else if (active_cmd_ff == CMD_INTERIM) begin
                        channel_moving_ff[idx] <= 1'b0;
                        channel_conf_ff[idx]   <= CONF_UNKNOWN;
                     end
                  end
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_GAP: begin
               want_ff   <= CMD_NONE;
               oldest_ff <= '0;
               if (active_cmd_ff == CMD_NONE && (!gap_active_ff || reached(now_ff, gap_end_ff)))
               begin
                  gap_active_ff <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= S_SCAN;
               end else begin
                  cnt_ff   <= {1'b0, ch_ff};
                  state_ff <= S_REPORT;
               end
            end
            S_SCAN: begin
               // Find the oldest pending request
               if (idx_end) begin
                  mask_ff <= '0;
                  if (want_ff == CMD_NONE) begin
                     cnt_ff   <= {1'b0, ch_ff};
                     state_ff <= S_REPORT;
                  end else begin
                     cnt_ff   <= '0;
                     state_ff <= S_GATHER;
                  end
               end else begin
                  if (pending_cmd_ff[idx] != CMD_NONE &&
                      (want_ff == CMD_NONE || pending_stamp_ff[idx] < oldest_ff)) begin
                     want_ff   <= pending_cmd_ff[idx];
                     oldest_ff <= pending_stamp_ff[idx];
                  end
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_GATHER: begin
               // Batch every channel that wants the same command
               if (idx_end) begin
                  active_cmd_ff  <= want_ff;
                  active_mask_ff <= mask_ff;
                  pulse_end_ff <= now_ff + TIME_W'((want_ff == CMD_INTERIM)
                                  ? eff_hold(interim_cfg_ff, INTERIM_DFLT)
                                  : eff_hold(pulse_cfg_ff, PULSE_DFLT));
                  gap_active_ff <= 1'b0;
                  cnt_ff   <= {1'b0, ch_ff};
                  state_ff <= S_REPORT;
               end else begin
                  if (pending_cmd_ff[idx] == want_ff) begin
                     mask_ff[idx] <= 1'b1;
                     pending_cmd_ff[idx] <= CMD_NONE;
                  end
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_REPORT: begin
               // Load the response once the register is free
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_acc_ff   <= acc_ff;
                  rsp_cmd_ff   <= active_cmd_ff;
                  rsp_mask_ff  <= (active_cmd_ff != CMD_NONE) ? (active_mask_ff & used_mask)
                                                              : '0;
                  rsp_busy_ff  <= (active_cmd_ff != CMD_NONE) || any_pending;
                  rsp_pos_ff    <= ch_ok ? channel_pos_ff[idx] : '0;
                  rsp_conf_ff   <= ch_ok ? channel_conf_ff[idx] : CONF_UNKNOWN;
                  rsp_moving_ff <= ch_ok ? channel_moving_ff[idx] : 1'b0;
                  rsp_last_ff   <= ch_ok ? channel_last_ff[idx] : CMD_NONE;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_gap_idle: assert property (@(posedge clock) disable iff (reset)
      gap_active_ff |-> active_cmd_ff == CMD_NONE) else $error("gap while batch active");
   a_mask_idle: assert property (@(posedge clock) disable iff (reset)
      active_cmd_ff == CMD_NONE |-> active_mask_ff == '0) else $error("mask without batch");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider result outside divide step");
   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_REPORT)
      else $error("response raised outside report step");
endmodule

/* tb/sv/tb_scb_if.sv */
// Testbench item types for the request and result channels.
package tb_scb_types;
   import scb_pkg::*;

   // One input item as seen on the request channel
   typedef struct {
      logic [1:0]      mode;
      logic [CH_W-1:0] channel;
      cmd_type         command;
      time_type        now_ms;
      time_type        travel_up;
      time_type        travel_down;
   } shade_req_type;

   // One result item
   typedef struct {
      logic       accepted;
      cmd_type    batch_cmd;
      logic [7:0] assert_mask;
      logic       busy_res;
      pos_type    position;
      conf_type   confidence;
      logic       moving;
      cmd_type    released_cmd;
   } shade_rsp_type;
endpackage

/* tb/sv/tb_shade_command_batcher.sv */
// Testbench for the shade command batcher: random and directed items, predicted results.
module tb_shade_command_batcher;
   timeunit 1ns;
   timeprecision 1ps;
   import scb_pkg::*;
   import tb_scb_types::*;

   // Scoreboard: predicts each result from its own copy of the block state
   class shade_scoreboard;
      int unsigned n_chan, pulse_hold, interim_hold, guard_gap;
      cmd_type     want_cmd [MAX_CHANNELS];
      bit [31:0]   want_seq [MAX_CHANNELS];
      bit [31:0]   seq_no;
      bit [9:0]    pos [MAX_CHANNELS];
      conf_type    conf [MAX_CHANNELS];
      bit          mov [MAX_CHANNELS];
      bit          going_up [MAX_CHANNELS];
      bit [31:0]   start_t [MAX_CHANNELS];
      bit [9:0]    start_p [MAX_CHANNELS];
      cmd_type     sent [MAX_CHANNELS];
      bit [31:0]   span_up [MAX_CHANNELS];
      bit [31:0]   span_dn [MAX_CHANNELS];
      cmd_type     on_cmd;
      bit [7:0]    on_mask;
      bit [31:0]   pulse_end;
      bit          in_gap;
      bit [31:0]   gap_end;
      shade_rsp_type pending_rsp [$];
      int          errors;

      function void clear();
         n_chan = 8; pulse_hold = 500; interim_hold = 3000; guard_gap = 250;
         seq_no = 0; on_cmd = CMD_NONE; on_mask = 0; pulse_end = 0;
         in_gap = 0; gap_end = 0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            want_cmd[i] = CMD_NONE; want_seq[i] = 0; pos[i] = 0;
            conf[i] = CONF_UNKNOWN; mov[i] = 0; going_up[i] = 0; start_t[i] = 0;
            start_p[i] = 0; sent[i] = CMD_NONE; span_up[i] = 0; span_dn[i] = 0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned v);
         case (idx)
            CSR_COUNT:   n_chan = v & 'hF;
            CSR_PULSE:   pulse_hold = v & 'h3FFF;
            CSR_INTERIM: interim_hold = v & 'h3FFF;
            CSR_GAP:     guard_gap = v & 'hFFFF;
         endcase
      endfunction

      function int unsigned live_count();
         if (n_chan == 0) return 1;
         if (n_chan > MAX_CHANNELS) return MAX_CHANNELS;
         return n_chan;
      endfunction

      function bit [31:0] hold_of(int unsigned v, int unsigned dflt);
         if (v == 0) v = dflt;
         if (v > MAX_HOLD_MS) v = MAX_HOLD_MS;
         return v;
      endfunction

      function bit due(bit [31:0] now, bit [31:0] deadline);
         bit [31:0] d;
         d = now - deadline;
         return !d[31];
      endfunction

      // Dead-reckon one moving channel
      function void reckon(int i, bit [31:0] now);
         bit [31:0] span;
         bit [63:0] travelled;
         bit [31:0] el;
         if (!mov[i]) return;
         span = going_up[i] ? span_up[i] : span_dn[i];
         if (span == 0) begin
            conf[i] = CONF_UNKNOWN;
            return;
         end
         el = now - start_t[i];
         travelled = (64'(el) * 64'd1000) / 64'(span);
         if (going_up[i]) begin
            if (64'(start_p[i]) + travelled >= 64'd1000) begin
               pos[i] = 1000; mov[i] = 0; conf[i] = CONF_EXACT;
            end else begin
               pos[i] = start_p[i] + travelled[9:0]; conf[i] = CONF_ESTIMATED;
            end
         end else begin
            if (travelled >= 64'(start_p[i])) begin
               pos[i] = 0; mov[i] = 0; conf[i] = CONF_EXACT;
            end else begin
               pos[i] = start_p[i] - travelled[9:0]; conf[i] = CONF_ESTIMATED;
            end
         end
      endfunction

      // Advance time: positions, pulse end, guard gap, next batch
      function void run_tick(bit [31:0] now, int unsigned n);
         cmd_type   pick;
         bit [31:0] oldest;
         bit [7:0]  m;
         for (int i = 0; i < n; i++) reckon(i, now);
         if (on_cmd != CMD_NONE && due(now, pulse_end)) begin
            for (int i = 0; i < n; i++) begin
               if (!on_mask[i]) continue;
               sent[i] = on_cmd;
               if (on_cmd == CMD_UP || on_cmd == CMD_DOWN) begin
                  mov[i] = 1; going_up[i] = (on_cmd == CMD_UP);
                  start_t[i] = now; start_p[i] = pos[i];
                  if (conf[i] == CONF_EXACT) conf[i] = CONF_ESTIMATED;
               end else if (on_cmd == CMD_STOP) begin
                  mov[i] = 0;
               end else if (on_cmd == CMD_INTERIM) begin
                  mov[i] = 0; conf[i] = CONF_UNKNOWN;
               end
            end
            on_cmd = CMD_NONE; on_mask = 0; in_gap = 1;
            gap_end = now + (guard_gap == 0 ? 250 : guard_gap);
         end
         if (on_cmd == CMD_NONE && (!in_gap || due(now, gap_end))) begin
            in_gap = 0;
            pick = CMD_NONE; oldest = 0; m = 0;
            for (int i = 0; i < n; i++) begin
               if (want_cmd[i] == CMD_NONE) continue;
               if (pick == CMD_NONE || want_seq[i] < oldest) begin
                  pick = want_cmd[i]; oldest = want_seq[i];
               end
            end
            if (pick != CMD_NONE) begin
               for (int i = 0; i < n; i++)
                  if (want_cmd[i] == pick) begin
                     m[i] = 1; want_cmd[i] = CMD_NONE;
                  end
               on_cmd = pick; on_mask = m;
               pulse_end = now + (pick == CMD_INTERIM ? hold_of(interim_hold, 3000)
                                                      : hold_of(pulse_hold, 500));
               in_gap = 0;
            end
         end
      endfunction

      // Note an accepted input item and queue its expected result
      function void note_request(shade_req_type r);
         int unsigned n;
         shade_rsp_type e;
         n = live_count();
         e.accepted = 0;
         if (r.mode == MODE_CMD) begin
            if (r.channel < n && r.command != CMD_NONE && r.command <= CMD_INTERIM) begin
               seq_no++;
               want_cmd[r.channel] = r.command;
               want_seq[r.channel] = seq_no;
               e.accepted = 1;
            end
         end else if (r.mode == MODE_TICK) begin
            run_tick(r.now_ms, n);
         end else if (r.mode == MODE_LOAD) begin
            span_up[r.channel] = r.travel_up;
            span_dn[r.channel] = r.travel_down;
         end
         e.busy_res = (on_cmd != CMD_NONE);
         for (int i = 0; i < n; i++) if (want_cmd[i] != CMD_NONE) e.busy_res = 1;
         e.batch_cmd = on_cmd;
         e.assert_mask = (on_cmd != CMD_NONE) ? (on_mask & 8'((1 << n) - 1)) : 8'h0;
         if (r.channel < n) begin
            e.position = pos[r.channel]; e.confidence = conf[r.channel];
            e.moving = mov[r.channel]; e.released_cmd = sent[r.channel];
         end else begin
            e.position = 0; e.confidence = CONF_UNKNOWN; e.moving = 0;
            e.released_cmd = CMD_NONE;
         end
         pending_rsp.push_back(e);
      endfunction

      // Compare a result item with the oldest expectation
      function void check_result(shade_rsp_type a);
         shade_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("result item with no expectation waiting");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (a.accepted !== e.accepted) begin
            $error("accepted: expected %0d actual %0d", e.accepted, a.accepted); errors++;
         end
         if (a.batch_cmd !== e.batch_cmd) begin
            $error("batch_cmd: expected %0d actual %0d", e.batch_cmd, a.batch_cmd); errors++;
         end
         if (a.assert_mask !== e.assert_mask) begin
            $error("assert_mask: expected %h actual %h", e.assert_mask, a.assert_mask);
            errors++;
         end
         if (a.busy_res !== e.busy_res) begin
            $error("busy_res: expected %0d actual %0d", e.busy_res, a.busy_res); errors++;
         end
         if (a.position !== e.position) begin
            $error("position: expected %0d actual %0d", e.position, a.position); errors++;
         end
         if (a.confidence !== e.confidence) begin
            $error("confidence: expected %0d actual %0d", e.confidence, a.confidence);
            errors++;
         end
         if (a.moving !== e.moving) begin
            $error("moving: expected %0d actual %0d", e.moving, a.moving); errors++;
         end
         if (a.released_cmd !== e.released_cmd) begin
            $error("released_cmd: expected %0d actual %0d", e.released_cmd, a.released_cmd);
            errors++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   scb_req_if req_ch();
   scb_rsp_if rsp_ch();
   scb_csr_if csr_ch();

   shade_command_batcher uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   shade_scoreboard board;
   bit [31:0] clock_ms;
   int        idle_cycles;
   bit        stall_mode;

   // Free-running clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Check result items and count cycles without progress
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_result('{rsp_ch.accepted, rsp_ch.batch_cmd, rsp_ch.assert_mask,
                                 rsp_ch.busy_res, rsp_ch.position, rsp_ch.confidence,
                                 rsp_ch.moving, rsp_ch.released_cmd});
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Receiver stall pattern: alternate free-flowing and choppy stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // Send one item and hold it until accepted
   task automatic send_item(shade_req_type r);
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= r.mode;
      req_ch.channel     <= r.channel;
      req_ch.command     <= r.command;
      req_ch.now_ms      <= r.now_ms;
      req_ch.travel_up   <= r.travel_up;
      req_ch.travel_down <= r.travel_down;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
   endtask

   // Drop valid and idle for the given number of cycles
   task automatic idle_gap(int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      board.write_reg(idx, v);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic shade_req_type make_item(logic [1:0] m, int ch, int c, bit [31:0] t,
                                               bit [31:0] up, bit [31:0] dn);
      shade_req_type r;
      r.mode = m; r.channel = CH_W'(ch); r.command = CMD_W'(c); r.now_ms = t;
      r.travel_up = up; r.travel_down = dn;
      return r;
   endfunction

   // Mostly well-formed traffic: loads, commands, reports and steadily advancing ticks
   task automatic random_item();
      int k;
      bit [31:0] up, dn;
      k = $urandom_range(0, 99);
      if (k < 10) begin
         case ($urandom_range(0, 3))
            0: up = 0;
            1: up = $urandom;
            default: up = $urandom_range(1, 4000);
         endcase
         case ($urandom_range(0, 3))
            0: dn = 0;
            1: dn = $urandom;
            default: dn = $urandom_range(1, 4000);
         endcase
         send_item(make_item(MODE_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom, up, dn));
      end else if (k < 35) begin
         send_item(make_item(MODE_CMD, $urandom_range(0, 7),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(1, 4),
                             $urandom, $urandom, $urandom));
      end else if (k < 95) begin
         if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
         else clock_ms = clock_ms + $urandom_range(1, 800);
         send_item(make_item(MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 7),
                             clock_ms, $urandom, $urandom));
      end else begin
         send_item(make_item(MODE_REPORT, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom, $urandom, $urandom));
      end
   endtask

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && count > 0) begin
            random_item();
            burst--; count--;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
      end
   endtask

   initial begin
      board = new();
      board.clear();
      board.errors = 0;
      clock_ms = 32'hFFFF_F000;
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_CMD;
      req_ch.channel <= '0;
      req_ch.command <= CMD_NONE;
      req_ch.now_ms <= '0;
      req_ch.travel_up <= '0;
      req_ch.travel_down <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_COUNT;
      csr_ch.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: loads at extremes, every command, bad commands, pulse and gap wrap
      send_item(make_item(MODE_LOAD, 0, CMD_NONE, 0, 32'd1000, 32'd2000));
      send_item(make_item(MODE_LOAD, 1, CMD_NONE, 0, 32'hFFFF_FFFF, 32'd1));
      send_item(make_item(MODE_LOAD, 7, CMD_NONE, 0, 32'd0, 32'd0));
      send_item(make_item(MODE_CMD, 0, CMD_UP, 0, 0, 0));
      send_item(make_item(MODE_CMD, 1, CMD_UP, 0, 0, 0));
      send_item(make_item(MODE_CMD, 7, CMD_DOWN, 0, 0, 0));
      send_item(make_item(MODE_CMD, 2, CMD_NONE, 0, 0, 0));
      send_item(make_item(MODE_CMD, 3, 3'd7, 0, 0, 0));
      send_item(make_item(MODE_CMD, 4, CMD_INTERIM, 0, 0, 0));
      send_item(make_item(MODE_CMD, 5, CMD_STOP, 0, 0, 0));
      send_item(make_item(MODE_TICK, 0, CMD_NONE, 32'hFFFF_FF00, 0, 0));
      send_item(make_item(MODE_TICK, 0, CMD_NONE, 32'h0000_0100, 0, 0));
      send_item(make_item(MODE_TICK, 7, CMD_NONE, 32'h0000_0300, 0, 0));
      send_item(make_item(MODE_TICK, 1, CMD_NONE, 32'h0000_0600, 0, 0));
      send_item(make_item(MODE_TICK, 0, CMD_NONE, 32'h0000_1000, 0, 0));
      send_item(make_item(MODE_TICK, 4, CMD_NONE, 32'h0000_2000, 0, 0));
      send_item(make_item(MODE_TICK, 4, CMD_NONE, 32'h0000_6000, 0, 0));
      send_item(make_item(MODE_TICK, 0, CMD_NONE, 32'h8000_6000, 0, 0));
      send_item(make_item(MODE_REPORT, 7, CMD_NONE, 0, 0, 0));
      wait_drained();

      // Hold off until all results arrive, then narrow to two channels
      write_reg(CSR_COUNT, 16'd2);
      write_reg(CSR_PULSE, 16'd0);
      write_reg(CSR_INTERIM, 16'h3FFF);
      write_reg(CSR_GAP, 16'd0);
      send_item(make_item(MODE_CMD, 5, CMD_UP, 0, 0, 0));
      send_item(make_item(MODE_LOAD, 5, CMD_NONE, 0, 32'd50, 32'd60));
      send_item(make_item(MODE_REPORT, 5, CMD_NONE, 0, 0, 0));
      random_phase(300);
      wait_drained();

      write_reg(CSR_COUNT, 16'd0);
      write_reg(CSR_PULSE, 16'h3FFF);
      write_reg(CSR_INTERIM, 16'd0);
      write_reg(CSR_GAP, 16'hFFFF);
      random_phase(200);
      wait_drained();

      write_reg(CSR_COUNT, 16'd15);
      write_reg(CSR_PULSE, 16'd1);
      write_reg(CSR_INTERIM, 16'd10000);
      write_reg(CSR_GAP, 16'd1);
      random_phase(400);
      wait_drained();

      write_reg(CSR_COUNT, 16'd8);
      write_reg(CSR_PULSE, 16'd200);
      write_reg(CSR_INTERIM, 16'd900);
      write_reg(CSR_GAP, 16'd100);
      random_phase(430);
      wait_drained();
      repeat (400) @(posedge clock);

      if (board.errors == 0 && board.pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (board.pending_rsp.size() != 0)
            $error("%0d expected result items never arrived", board.pending_rsp.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/scb_pkg.sv
sv/scb_if.sv
sv/scb_div.sv
sv/shade_command_batcher.sv
tb/sv/tb_scb_if.sv
tb/sv/tb_shade_command_batcher.sv
